// ===== hw/rtl/shrl_pkg.sv =====
// shrl_pkg: shared constants, types and codes for the seed hit range lookup
// no dependencies; used by every rtl module of the block
`default_nettype none

package shrl_pkg;

	// overflow store geometry
	localparam int STORE_AW    = 16;
	localparam int STORE_DEPTH = 1 << STORE_AW;

	// entry word that marks an unused index slot
	localparam logic [31:0] UNUSED_MARK = 32'hffff_fffe;

	// binary search narrows the list down to at most this span plus one entries, then scans linearly
	localparam int NARROW_SPAN = 32;

	// front to back command queue
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	// request type codes
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef logic [STORE_AW-1:0] saddr_t;

	// command classes produced by the front end
	typedef enum logic [2:0] {
		OP_WRITE,
		OP_SINGLE,
		OP_UNUSED,
		OP_BAD,
		OP_LIST
	} op_t;

	// entry kind codes on the result channel
	typedef enum logic [1:0] {
		KIND_UNUSED = 2'd0,
		KIND_SINGLE = 2'd1,
		KIND_LIST   = 2'd2,
		KIND_BAD    = 2'd3
	} kind_t;

	// one queued command
	typedef struct packed {
		op_t         op;
		saddr_t      addr;
		logic [31:0] data;
		logic [31:0] min_loc;
		logic [31:0] max_loc;
		logic        in_window;
	} cmd_t;

	// queue status seen by both sides
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		B_IDLE,
		B_COUNT,
		B_BIN,
		B_CMP,
		B_SCAN1,
		B_SCAN2,
		B_DONE
	} bstate_t;

endpackage

`default_nettype wire

// ===== hw/rtl/shrl_if.sv =====
// shrl_if: valid/ready channel interfaces for lookup requests and results
// depends on nothing; field widths follow the block's item definition
`default_nettype none

interface shrl_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] store_address;
	logic [31:0] store_word;
	logic [31:0] entry_value;
	logic [31:0] min_location;
	logic [31:0] max_location;

	modport source (
		output valid, req_type, store_address, store_word,
		output entry_value, min_location, max_location,
		input  ready
	);
	modport sink (
		input  valid, req_type, store_address, store_word,
		input  entry_value, min_location, max_location,
		output ready
	);
endinterface

interface shrl_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  entry_kind;
	logic [15:0] hit_count;
	logic [15:0] first_hit_address;
	logic [31:0] single_location;

	modport source (
		output valid, entry_kind, hit_count, first_hit_address, single_location,
		input  ready
	);
	modport sink (
		input  valid, entry_kind, hit_count, first_hit_address, single_location,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/seed_hit_range_lookup.sv =====
// seed_hit_range_lookup: top level, front end, command queue and search back end
// a popped write goes to the store and a popped direct entry to the result register; list
// entries read the count word, make B binary search probes (up to 11 for the longest
// list) and scan S elements, one store read each; writes and direct entries sustain one
// item per cycle while the back end is idle and the result register is free; the single
// store port paces list searches; reset clears control state and count_of_bases only
`default_nettype none

module seed_hit_range_lookup
	import shrl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	shrl_req_if.sink         req,
	shrl_rsp_if.source       rsp
);

	qstat_t q_stat;
	logic   q_push;
	logic   q_pop;
	cmd_t   push_cmd;
	cmd_t   pop_cmd;

	// accept and classify
	shrl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_cmd       (push_cmd)
	);

	// decoupling queue
	shrl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.stat     (q_stat)
	);

	// store and search
	shrl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_cmd  (pop_cmd),
		.q_pop  (q_pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/shrl_front.sv =====
// shrl_front: accepts request items, holds count_of_bases, classifies entries
// depends on shrl_pkg and shrl_req_if; pushes commands into shrl_queue
`default_nettype none

module shrl_front
	import shrl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	shrl_req_if.sink         req,
	input  wire qstat_t      q_stat,
	output logic             q_push,
	output cmd_t             q_cmd
);

	logic [31:0] count_of_bases_q;
	logic [31:0] offset;
	logic        offset_ok;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_of_bases_q <= '0;
		end else if (cfg_wr_en) begin
			count_of_bases_q <= cfg_wr_data;
		end
	end

	// handshake: take an item whenever the queue has room
	assign req.ready = !q_stat.full;
	assign q_push    = req.valid && !q_stat.full;

	// store offset of a list entry
	assign offset    = req.entry_value - count_of_bases_q;
	assign offset_ok = offset < 32'(STORE_DEPTH);

	// classify the item
	always_comb begin
		q_cmd.op        = OP_WRITE;
		q_cmd.addr      = STORE_AW'(req.store_address);
		q_cmd.data      = req.store_word;
		q_cmd.min_loc   = req.min_location;
		q_cmd.max_loc   = req.max_location;
		q_cmd.in_window = 1'b0;
		if (req.req_type == REQ_LOOKUP) begin
			q_cmd.data = req.entry_value;
			priority if (req.entry_value < count_of_bases_q) begin
				q_cmd.op        = OP_SINGLE;
				q_cmd.in_window = (req.entry_value >= req.min_location) &&
					(req.entry_value <= req.max_location);
			end else if (req.entry_value == UNUSED_MARK) begin
				q_cmd.op = OP_UNUSED;
			end else if (!offset_ok) begin
				q_cmd.op = OP_BAD;
			end else begin
				q_cmd.op   = OP_LIST;
				q_cmd.addr = offset[STORE_AW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/shrl_queue.sv =====
// shrl_queue: short command fifo between front and back end
// depends on shrl_pkg for cmd_t, qstat_t and the queue depth
`default_nettype none

module shrl_queue
	import shrl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      pop_cmd,
	output qstat_t    stat
);

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_cmd    = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/shrl_back.sv =====
// shrl_back: overflow store and search sequencer, plus the result register
// depends on shrl_pkg and shrl_rsp_if; pops commands from shrl_queue
`default_nettype none

module shrl_back
	import shrl_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire qstat_t q_stat,
	input  wire cmd_t   q_cmd,
	output logic        q_pop,
	shrl_rsp_if.source  rsp
);

	// overflow store
	logic [31:0] mem [STORE_DEPTH];
	logic [31:0] rd_data_q;
	logic        mem_we;
	logic        mem_re;
	saddr_t      mem_raddr;

	// sequencer registers
	bstate_t     state_q, state_d;
	saddr_t      base_q, base_d;
	saddr_t      off_q, off_d;
	logic [15:0] n_q, n_d;
	logic [15:0] lo_q, lo_d;
	logic [15:0] hip_q, hip_d;
	logic [15:0] mid_q, mid_d;
	logic [15:0] stop_q, stop_d;
	logic [31:0] min_q, min_d;
	logic [31:0] max_q, max_d;
	kind_t       kind_q, kind_d;

	// result register
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [15:0] out_count_q;
	logic [15:0] out_addr_q;
	logic [31:0] out_loc_q;
	logic        out_free;
	logic        ld;
	kind_t       ld_kind;
	logic [15:0] ld_count;
	logic [15:0] ld_addr;
	logic [31:0] ld_loc;

	logic [32:0] list_end;
	logic        narrow_more;
	logic [15:0] half_span;

	assign out_free = !out_valid_q || rsp.ready;

	// list end check and binary search step
	assign list_end    = 33'(off_q) + 33'(rd_data_q);
	assign narrow_more = (17'(lo_q) + 17'(NARROW_SPAN + 1)) < 17'(hip_q);
	assign half_span   = (hip_q - 16'd1 - lo_q) >> 1;

	// store port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_cmd.addr] <= q_cmd.data;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// sequencer next state and outputs
	always_comb begin
		state_d   = state_q;
		base_d    = base_q;
		off_d     = off_q;
		n_d       = n_q;
		lo_d      = lo_q;
		hip_d     = hip_q;
		mid_d     = mid_q;
		stop_d    = stop_q;
		min_d     = min_q;
		max_d     = max_q;
		kind_d    = kind_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = base_q + STORE_AW'(lo_q);
		ld        = 1'b0;
		ld_kind   = KIND_UNUSED;
		ld_count  = '0;
		ld_addr   = '0;
		ld_loc    = '0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_stat.empty) begin
					unique case (q_cmd.op)
						OP_WRITE: begin
							mem_we = 1'b1;
							q_pop  = 1'b1;
						end
						OP_SINGLE: begin
							if (out_free) begin
								ld       = 1'b1;
								ld_kind  = KIND_SINGLE;
								ld_count = {15'd0, q_cmd.in_window};
								ld_loc   = q_cmd.data;
								q_pop    = 1'b1;
							end
						end
						OP_UNUSED: begin
							if (out_free) begin
								ld      = 1'b1;
								ld_kind = KIND_UNUSED;
								q_pop   = 1'b1;
							end
						end
						OP_BAD: begin
							if (out_free) begin
								ld      = 1'b1;
								ld_kind = KIND_BAD;
								q_pop   = 1'b1;
							end
						end
						OP_LIST: begin
							mem_re    = 1'b1;
							mem_raddr = q_cmd.addr;
							off_d     = q_cmd.addr;
							base_d    = q_cmd.addr + 1'b1;
							min_d     = q_cmd.min_loc;
							max_d     = q_cmd.max_loc;
							q_pop     = 1'b1;
							state_d   = B_COUNT;
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			// count word is in; reject lists that run off the store
			B_COUNT: begin
				if (list_end >= 33'(STORE_DEPTH)) begin
					kind_d  = KIND_BAD;
					state_d = B_DONE;
				end else begin
					kind_d  = KIND_LIST;
					n_d     = rd_data_q[15:0];
					lo_d    = '0;
					hip_d   = rd_data_q[15:0];
					state_d = B_BIN;
				end
			end
			// pick the probe, or start the scan once the span is narrow
			B_BIN: begin
				mem_re = 1'b1;
				if (narrow_more) begin
					mid_d     = lo_q + half_span;
					mem_raddr = base_q + STORE_AW'(lo_q + half_span);
					state_d   = B_CMP;
				end else begin
					mem_raddr = base_q + STORE_AW'(lo_q);
					state_d   = B_SCAN1;
				end
			end
			B_CMP: begin
				if (rd_data_q <= max_q) begin
					hip_d = mid_q + 16'd1;
				end else begin
					lo_d = mid_q + 16'd1;
				end
				state_d = B_BIN;
			end
			// skip locations above the window, reading one ahead
			B_SCAN1: begin
				priority if (lo_q >= n_q) begin
					stop_d  = lo_q;
					state_d = B_DONE;
				end else if (rd_data_q > max_q) begin
					lo_d      = lo_q + 16'd1;
					mem_re    = 1'b1;
					mem_raddr = base_q + STORE_AW'(lo_q + 16'd1);
				end else if (rd_data_q >= min_q) begin
					stop_d    = lo_q + 16'd1;
					mem_re    = 1'b1;
					mem_raddr = base_q + STORE_AW'(lo_q + 16'd1);
					state_d   = B_SCAN2;
				end else begin
					stop_d  = lo_q;
					state_d = B_DONE;
				end
			end
			// count the run that stays at or above the minimum
			B_SCAN2: begin
				priority if (stop_q >= n_q) begin
					state_d = B_DONE;
				end else if (rd_data_q >= min_q) begin
					stop_d    = stop_q + 16'd1;
					mem_re    = 1'b1;
					mem_raddr = base_q + STORE_AW'(stop_q + 16'd1);
				end else begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_kind = kind_q;
					if (kind_q == KIND_LIST) begin
						ld_count = stop_q - lo_q;
						ld_addr  = 16'(base_q + STORE_AW'(lo_q));
					end
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// search working registers
	always_ff @(posedge clk) begin
		base_q <= base_d;
		off_q  <= off_d;
		n_q    <= n_d;
		lo_q   <= lo_d;
		hip_q  <= hip_d;
		mid_q  <= mid_d;
		stop_q <= stop_d;
		min_q  <= min_d;
		max_q  <= max_d;
		kind_q <= kind_d;
	end

	// result item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result item payload
	always_ff @(posedge clk) begin
		if (ld) begin
			out_kind_q  <= ld_kind;
			out_count_q <= ld_count;
			out_addr_q  <= ld_addr;
			out_loc_q   <= ld_loc;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.entry_kind        = out_kind_q;
	assign rsp.hit_count         = out_count_q;
	assign rsp.first_hit_address = out_addr_q;
	assign rsp.single_location   = out_loc_q;

endmodule

`default_nettype wire

// ===== bench/seed_hit_range_lookup_check.sv =====
`timescale 1ns / 100ps
// seed_hit_range_lookup_check: watches the request, result and config ports, predicts results
// depends on shrl_pkg and the shrl_req_if / shrl_rsp_if channel interfaces

module seed_hit_range_lookup_check
	import shrl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	shrl_req_if         req,
	shrl_rsp_if         rsp,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		kind_t       kind;
		logic [15:0] hits;
		logic [15:0] first_addr;
		logic [31:0] location;
	} hit_result_t;

	// own copy of the register and the overflow store
	logic [31:0] bases;
	logic [31:0] store_mem [STORE_DEPTH];
	hit_result_t hits_due [$];

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// classify the entry, then binary search and scan the hit list
	function automatic hit_result_t search_hits(input logic [31:0] entry,
			input logic [31:0] lo_loc, input logic [31:0] hi_loc);
		hit_result_t r;
		logic [31:0] diff;
		logic [63:0] wide;
		longint      offset, count, base, lo, hi, stop, mid;
		r = '0;
		r.kind = KIND_UNUSED;
		if (entry < bases) begin
			r.kind = KIND_SINGLE;
			r.hits = (entry >= lo_loc && entry <= hi_loc) ? 16'd1 : 16'd0;
			r.location = entry;
			return r;
		end
		if (entry == UNUSED_MARK) begin
			return r;
		end
		diff = entry - bases;
		offset = diff;
		if (offset >= STORE_DEPTH) begin
			r.kind = KIND_BAD;
			return r;
		end
		count = store_mem[offset];
		if (offset + count >= STORE_DEPTH) begin
			r.kind = KIND_BAD;
			return r;
		end
		base = offset + 1;
		lo = 0;
		hi = count - 1;
		// narrow down to a short span first
		while (lo < hi - NARROW_SPAN) begin
			mid = lo + (hi - lo) / 2;
			if (store_mem[base + mid] <= hi_loc) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		// skip locations above the window, then count the run inside it
		while (lo < count && store_mem[base + lo] > hi_loc) lo++;
		stop = lo;
		while (stop < count && store_mem[base + stop] >= lo_loc) stop++;
		r.kind = KIND_LIST;
		wide = stop - lo;
		r.hits = (wide > 64'd65535) ? 16'hffff : wide[15:0];
		wide = base + lo;
		r.first_addr = wide[15:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		hit_result_t due;
		if (!arst_n) begin
			bases = '0;
			hits_due.delete();
		end else begin
			// results first, so a result never matches an item taken in the same cycle
			if (rsp.valid && rsp.ready) begin
				if (hits_due.size() == 0) begin
					report_mismatch($sformatf("result kind %0d with no lookup outstanding",
						rsp.entry_kind));
				end else begin
					due = hits_due.pop_front();
					if (rsp.entry_kind !== due.kind)
						report_mismatch($sformatf("entry_kind %0d, expected %0d",
							rsp.entry_kind, due.kind));
					if (rsp.hit_count !== due.hits)
						report_mismatch($sformatf("hit_count %0d, expected %0d",
							rsp.hit_count, due.hits));
					if (rsp.first_hit_address !== due.first_addr)
						report_mismatch($sformatf("first_hit_address %0d, expected %0d",
							rsp.first_hit_address, due.first_addr));
					if (rsp.single_location !== due.location)
						report_mismatch($sformatf("single_location %h, expected %h",
							rsp.single_location, due.location));
				end
			end
			// store writes and lookups
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_WRITE) begin
					store_mem[req.store_address] = req.store_word;
				end else begin
					hits_due.push_back(search_hits(req.entry_value, req.min_location,
						req.max_location));
				end
			end
			if (cfg_wr_en) begin
				bases = cfg_wr_data;
			end
		end
		outstanding <= hits_due.size();
	end

endmodule

// ===== bench/seed_hit_range_lookup_tb.sv =====
`timescale 1ns / 100ps
// seed_hit_range_lookup_tb: clock, reset, config writes and item stimulus, plus the verdict
// depends on shrl_pkg, the channel interfaces, seed_hit_range_lookup and its checker

module seed_hit_range_lookup_tb;
	import shrl_pkg::*;

	localparam int     RANDOM_ITEMS  = 1750;
	localparam int     PHASES        = 6;
	localparam int     SETTLE_CYCLES = 16;
	localparam int     QUIET_LIMIT   = 20000;
	localparam longint LOC_TOP       = 64'h0000_0000_ffff_ffff;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        steady = 1'b0;
	int          mismatches;
	int          outstanding;
	int          quiet = 0;
	int          items_sent = 0;
	longint      bases_now = 0;

	// what has been written to the store, so lookups only touch written words
	bit          written [STORE_DEPTH];
	logic [31:0] image [STORE_DEPTH];

	shrl_req_if req_ch ();
	shrl_rsp_if rsp_ch ();

	seed_hit_range_lookup DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	seed_hit_range_lookup_check lookup_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	// result side stalls at random, except in the steady stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_wr_en) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("seed_hit_range_lookup_tb NOT OK");
				$finish;
			end
		end
	end

	function automatic logic [31:0] clamp_loc(input longint v);
		logic [63:0] w;
		if (v < 0) return 32'h0;
		if (v > LOC_TOP) return 32'hffff_ffff;
		w = v;
		return w[31:0];
	endfunction

	// an offset can be named by an entry only if base count plus offset fits
	function automatic bit entry_reachable(input longint off);
		return (bases_now + off <= LOC_TOP) && (bases_now + off != longint'(UNUSED_MARK));
	endfunction

	// a list lookup at this offset reads only written words
	function automatic bit list_reads_written(input longint off);
		longint n;
		if (!written[off]) return 1'b0;
		n = image[off];
		if (off + n >= STORE_DEPTH) return 1'b1;
		for (longint i = 1; i <= n; i++) begin
			if (!written[off + i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	// offer one item, idling at random first, and wait for it to be taken
	task automatic put_item(input logic rtype, input logic [15:0] addr, input logic [31:0] word,
			input logic [31:0] entry, input logic [31:0] lo_loc, input logic [31:0] hi_loc);
		while (!steady && $urandom_range(0, 99) < 26) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= rtype;
		req_ch.store_address <= addr;
		req_ch.store_word    <= word;
		req_ch.entry_value   <= entry;
		req_ch.min_location  <= lo_loc;
		req_ch.max_location  <= hi_loc;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		items_sent++;
	endtask

	task automatic store_write(input longint addr, input logic [31:0] word);
		written[addr] = 1'b1;
		image[addr] = word;
		put_item(REQ_WRITE, addr[15:0], word, $urandom, $urandom, $urandom);
	endtask

	task automatic lookup(input logic [31:0] entry, input logic [31:0] lo_loc,
			input logic [31:0] hi_loc);
		put_item(REQ_LOOKUP, $urandom_range(0, 65535), $urandom, entry, lo_loc, hi_loc);
	endtask

	// hold the sender until every result is back and the block has settled
	task automatic wait_idle(input int settle);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_bases(input logic [31:0] v);
		wait_idle(SETTLE_CYCLES);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		bases_now = v;
	endtask

	// write a count word and a non-increasing (now and then jumbled) location list
	task automatic build_list(input bit big, output longint off);
		longint n, lim, span, step, v;
		bit     jumbled;
		if (big) begin
			n = $urandom_range(400, 700);
		end else if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(34, 250);
		end else begin
			n = $urandom_range(0, 33);
		end
		lim = STORE_DEPTH - 1 - n;
		if (LOC_TOP - bases_now < lim) lim = LOC_TOP - bases_now;
		off = ($urandom_range(0, 9) == 0) ? lim : $urandom_range(0, lim);
		if (!entry_reachable(off)) off--;
		jumbled = ($urandom_range(0, 9) == 0);
		case ($urandom_range(0, 3))
			0: span = 0;
			1: span = 4;
			2: span = 5000;
			default: span = 1 << 24;
		endcase
		v = ($urandom_range(0, 7) == 0) ? LOC_TOP : longint'($urandom);
		store_write(off, n);
		for (longint i = 1; i <= n; i++) begin
			store_write(off + i, jumbled ? $urandom : clamp_loc(v));
			step = $urandom_range(0, span);
			v = (v > step) ? v - step : 0;
		end
	endtask

	// look up the list at an offset with windows in and around its contents, else the unused mark
	task automatic probe_list(input longint off);
		longint n, a, b, t;
		logic [31:0] entry;
		if (!entry_reachable(off) || !list_reads_written(off)) begin
			lookup(UNUSED_MARK, $urandom, $urandom);
		end else begin
			entry = bases_now + off;
			n = image[off];
			if (off + n >= STORE_DEPTH || n == 0) begin
				a = $urandom;
				b = $urandom;
			end else begin
				a = image[off + 1 + $urandom_range(0, n - 1)];
				b = image[off + 1 + $urandom_range(0, n - 1)];
			end
			if (a < b) begin
				t = a;
				a = b;
				b = t;
			end
			case ($urandom_range(0, 7))
				0: lookup(entry, 32'h0, 32'hffff_ffff);
				1: lookup(entry, $urandom, $urandom);
				2: lookup(entry, clamp_loc(b), clamp_loc(a));
				3: lookup(entry, clamp_loc(b - $urandom_range(0, 3)),
					clamp_loc(a + $urandom_range(0, 3)));
				4: lookup(entry, clamp_loc(a), clamp_loc(a));
				5: lookup(entry, 32'h0, clamp_loc(b - 1));
				6: lookup(entry, clamp_loc(a + 1), 32'hffff_ffff);
				default: lookup(entry, clamp_loc(a), clamp_loc(b));
			endcase
		end
	endtask

	// noise between list lookups: singles, unused, bad references, stale offsets, stray writes
	task automatic stray_item();
		longint e, d, lim, off;
		lim = STORE_DEPTH - 1;
		if (LOC_TOP - bases_now < lim) lim = LOC_TOP - bases_now;
		off = $urandom_range(0, lim);
		case ($urandom_range(0, 5))
			0: begin
				if (bases_now == 0) begin
					lookup(UNUSED_MARK, $urandom, $urandom);
				end else begin
					e = $urandom_range(0, bases_now - 1);
					d = $urandom_range(0, 4);
					case ($urandom_range(0, 4))
						0: lookup(e, e, e);
						1: lookup(e, clamp_loc(e - d), clamp_loc(e + d));
						2: lookup(e, $urandom, $urandom);
						3: lookup(e, clamp_loc(e + 1), 32'hffff_ffff);
						default: lookup(e, 32'h0, clamp_loc(e - 1));
					endcase
				end
			end
			1: lookup(UNUSED_MARK, $urandom, $urandom);
			2: begin
				if (bases_now + STORE_DEPTH <= LOC_TOP) begin
					e = $urandom_range(bases_now + STORE_DEPTH, 32'hffff_ffff);
					if (e == longint'(UNUSED_MARK)) e = LOC_TOP;
					lookup(e, $urandom, $urandom);
				end else begin
					lookup(UNUSED_MARK, $urandom, $urandom);
				end
			end
			3: begin
				// count word that runs past the end of the store
				if (!entry_reachable(off)) off--;
				store_write(off, $urandom_range(STORE_DEPTH - off, 32'hffff_ffff));
				lookup(bases_now + off, $urandom, $urandom);
			end
			4: probe_list(off);
			default: store_write($urandom_range(0, 65535), $urandom);
		endcase
	endtask

	initial begin : stimulus
		longint      off;
		logic [31:0] phase_bases;
		int          quota;
		bit          big;
		req_ch.valid         <= 1'b0;
		req_ch.req_type      <= REQ_WRITE;
		req_ch.store_address <= '0;
		req_ch.store_word    <= '0;
		req_ch.entry_value   <= '0;
		req_ch.min_location  <= '0;
		req_ch.max_location  <= '0;
		cfg_wr_en            <= 1'b0;
		cfg_wr_data          <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unused marker, offsets past the store, short lists, store end
		lookup(UNUSED_MARK, 32'h0, 32'hffff_ffff);
		lookup(32'hffff_ffff, 32'h0, 32'hffff_ffff);
		lookup(32'h0001_0000, 32'h0, 32'h0);
		store_write(0, 32'd0);
		lookup(32'd0, 32'h0, 32'hffff_ffff);
		store_write(1, 32'd2);
		store_write(2, 32'd100);
		store_write(3, 32'd50);
		lookup(32'd1, 32'd50, 32'd100);
		lookup(32'd1, 32'd51, 32'd99);
		lookup(32'd1, 32'h0, 32'h0);
		lookup(32'd1, 32'h0, 32'hffff_ffff);
		store_write(STORE_DEPTH - 2, 32'd1);
		store_write(STORE_DEPTH - 1, 32'hffff_ffff);
		lookup(STORE_DEPTH - 2, 32'h0, 32'hffff_ffff);
		// empty run just past the last word: address wraps
		lookup(STORE_DEPTH - 2, 32'h0, 32'hffff_fffe);
		lookup(STORE_DEPTH - 1, 32'h0, 32'hffff_ffff);

		// direct locations, and one list entry just above them
		set_bases(32'd10);
		lookup(32'd0, 32'h0, 32'h0);
		lookup(32'd9, 32'd10, 32'hffff_ffff);
		lookup(32'd5, 32'd6, 32'd4);
		lookup(32'd11, 32'd50, 32'd100);

		// largest base count: only a few offsets remain reachable
		set_bases(32'hffff_fff0);
		lookup(32'hffff_ffef, 32'hffff_ffef, 32'hffff_ffff);
		lookup(32'hffff_fff0, 32'h0, 32'hffff_ffff);
		lookup(UNUSED_MARK, 32'h0, 32'h0);
		lookup(32'hffff_fff1, 32'd100, 32'd100);

		// random phases, each with its own base count, sharing one item budget
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: phase_bases = 32'd0;
				1: phase_bases = 32'hffff_fff0;
				2: phase_bases = $urandom_range(1, 65535);
				3: phase_bases = 32'h8000_0000;
				4: phase_bases = 32'd1;
				default: phase_bases = $urandom_range(0, 32'hffff_fff0);
			endcase
			set_bases(phase_bases);
			steady = (phase == 2);
			big = (phase == 3);
			quota = (phase + 1) * RANDOM_ITEMS / PHASES;
			do begin
				build_list(big, off);
				big = 1'b0;
				repeat ($urandom_range(4, 14)) begin
					if ($urandom_range(0, 3) == 0) begin
						stray_item();
					end else begin
						probe_list(off);
					end
				end
			end while (items_sent < quota);
		end
		steady = 1'b0;

		wait_idle(50);
		if (mismatches == 0 && outstanding == 0) begin
			$display("seed_hit_range_lookup_tb OK");
		end else begin
			$display("seed_hit_range_lookup_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/shrl_pkg.sv
hw/rtl/shrl_if.sv
hw/rtl/shrl_front.sv
hw/rtl/shrl_queue.sv
hw/rtl/shrl_back.sv
hw/rtl/seed_hit_range_lookup.sv
bench/seed_hit_range_lookup_check.sv
bench/seed_hit_range_lookup_tb.sv
